>>> sv/engine_speed_governor_step_defines.svh
// Assertion helpers for the engine speed governor step block.
`ifndef ENGINE_SPEED_GOVERNOR_STEP_DEFINES_SVH
`define ENGINE_SPEED_GOVERNOR_STEP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ESG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esg check failed");

// Next-cycle implication, checked out of reset
`define ESG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esg check failed");

`endif

>>> sv/esg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_SPEED = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_WARMUP_TIME  = 3'd3,
    REG_WARMUP_RATE  = 3'd4
  } cfg_reg_t;

  // Datapath operations, one per sequencer step
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WARM0, OP_WARM1,
    OP_SM0, OP_SM1, OP_SM2, OP_SM3, OP_SM4,
    OP_GSLOW, OP_G0, OP_G1, OP_G2, OP_G3, OP_G4, OP_G5, OP_G6,
    OP_T0, OP_T1, OP_P0, OP_P1, OP_OUT
  } dp_op_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_WARM0, ST_WARM1,
    ST_SM0, ST_SM1, ST_SM2, ST_SM3, ST_SM4,
    ST_GSLOW, ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6,
    ST_T0, ST_T1, ST_P0, ST_P1, ST_OUT
  } esg_state_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } esg_cmd_t;

  typedef struct packed {
    logic mode;
    logic ign;
    logic warm_go;
    logic gov_en;
    logic gov_slow;
    logic out_full;
  } esg_status_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  // Register reset values
  localparam logic [16:0] TARGET_RST = 17'd12800;
  localparam logic [23:0] PGAIN_RST  = 24'd33554;
  localparam logic [23:0] IGAIN_RST  = 24'd1678;
  localparam logic [17:0] WTIME_RST  = 18'd131072;
  localparam logic [15:0] WRATE_RST  = 16'd9830;
  localparam logic [15:0] WEIGHT_RST = 16'd52429;

  // Smoothing ratio times 3277, by request band
  localparam logic [27:0] RT_LOW = 28'(58982 * 3277);
  localparam logic [27:0] RT_MID = 28'(52429 * 3277);
  localparam logic [27:0] RT_HIGH = 28'(45875 * 3277);

  function automatic logic [27:0] ratio_term(input logic [15:0] req);
    logic [27:0] r;
    if (req < 16'd6554) r = RT_LOW;
    else if (req < 16'd19661) r = RT_MID;
    else r = RT_HIGH;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/esg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module esg_ctrl
  import esg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        out_ready,
  input  wire esg_status_t status,
  output esg_cmd_t         cmd,
  output logic             in_ready
);

  esg_state_t state_r, state_nxt;
  logic       pass_r, pass_nxt;

  // State register; pass_r marks a pending second smoothing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (status.mode || !status.ign) begin
          state_nxt = ST_P0;
        end else if (status.warm_go) begin
          state_nxt = ST_WARM0;
          pass_nxt  = 1'b1;
        end else begin
          state_nxt = ST_SM0;
        end
      end
      ST_WARM0: state_nxt = ST_WARM1;
      ST_WARM1: state_nxt = ST_SM0;
      ST_SM0:   state_nxt = ST_SM1;
      ST_SM1:   state_nxt = ST_SM2;
      ST_SM2:   state_nxt = ST_SM3;
      ST_SM3:   state_nxt = ST_SM4;
      ST_SM4: begin
        if (pass_r) begin
          pass_nxt  = 1'b0;
          state_nxt = ST_SM0;
        end else if (status.gov_en && !status.gov_slow) begin
          state_nxt = ST_G0;
        end else if (status.gov_en) begin
          state_nxt = ST_GSLOW;
        end else begin
          state_nxt = ST_T0;
        end
      end
      ST_GSLOW: state_nxt = ST_T0;
      ST_G0:    state_nxt = ST_G1;
      ST_G1:    state_nxt = ST_G2;
      ST_G2:    state_nxt = ST_G3;
      ST_G3:    state_nxt = ST_G4;
      ST_G4:    state_nxt = ST_G5;
      ST_G5:    state_nxt = ST_G6;
      ST_G6:    state_nxt = ST_T0;
      ST_T0:    state_nxt = ST_T1;
      ST_T1:    state_nxt = ST_P0;
      ST_P0:    state_nxt = ST_P1;
      ST_P1:    state_nxt = ST_OUT;
      ST_OUT:   if (!status.out_full || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    case (state_r)
      ST_LOAD:  cmd.op = OP_LOAD;
      ST_WARM0: cmd.op = OP_WARM0;
      ST_WARM1: cmd.op = OP_WARM1;
      ST_SM0:   cmd.op = OP_SM0;
      ST_SM1:   cmd.op = OP_SM1;
      ST_SM2:   cmd.op = OP_SM2;
      ST_SM3:   cmd.op = OP_SM3;
      ST_SM4:   cmd.op = OP_SM4;
      ST_GSLOW: cmd.op = OP_GSLOW;
      ST_G0:    cmd.op = OP_G0;
      ST_G1:    cmd.op = OP_G1;
      ST_G2:    cmd.op = OP_G2;
      ST_G3:    cmd.op = OP_G3;
      ST_G4:    cmd.op = OP_G4;
      ST_G5:    cmd.op = OP_G5;
      ST_G6:    cmd.op = OP_G6;
      ST_T0:    cmd.op = OP_T0;
      ST_T1:    cmd.op = OP_T1;
      ST_P0:    cmd.op = OP_P0;
      ST_P1:    cmd.op = OP_P1;
      ST_OUT:   cmd.op = (!status.out_full || out_ready) ? OP_OUT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/esg_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module esg_dp
  import esg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire esg_cmd_t              cmd,
  output esg_status_t                status,
  input  wire logic                  in_mode,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [OUT_DATA_W-1:0]      out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration
  logic [16:0] target_r, target_nxt;
  logic [23:0] pg_r, pg_nxt, ig_r, ig_nxt;
  logic [17:0] wt_r, wt_nxt;
  logic [15:0] wr_r, wr_nxt;
  // Persistent state
  logic [16:0] speed_r, speed_nxt, prev_r, prev_nxt;
  logic [15:0] sl_r, sl_nxt, w_r, w_nxt;
  logic signed [17:0] integ_r, integ_nxt;
  logic [17:0] glast_r, glast_nxt, elapsed_r, elapsed_nxt;
  logic warm_r, warm_nxt, latch_r, latch_nxt, armed_r, armed_nxt;
  // Current item
  logic mode_r, ign_r, start_r;
  logic [15:0] req_r;
  logic [16:0] dt_r;
  // Work registers
  logic signed [49:0] prod_r;
  logic [15:0] sreq_r, sreq_nxt, load_r, load_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic signed [55:0] sum_r, sum_nxt;
  logic signed [31:0] raw_r, raw_nxt;
  logic [17:0] press_r, press_nxt;
  // Result register
  logic ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0] od_r;

  // Shared multiplier operands
  logic signed [24:0] mul_a, mul_b;

  // Helper terms
  logic [18:0] e_sum;
  logic [17:0] e_sat;
  logic        warm_done;
  logic [29:0] dec_prod;
  logic [13:0] dec_step;
  logic [33:0] up_prod;
  logic [31:0] dn_prod;
  logic signed [17:0] err, diff;
  logic [16:0] dt_in;
  logic [32:0] wsum, ssum, psum;
  logic signed [36:0] ia;
  logic signed [55:0] tot;
  logic [31:0] mag;
  logic [17:0] curved, lim;
  logic [18:0] hi, lo_chk;
  logic [15:0] g;
  logic [17:0] tgt0, tgt1;
  logic [18:0] spd_up, dn_lim, spd_new;

  assign e_sum     = {1'b0, elapsed_r} + {2'b0, dt_r};
  assign e_sat     = e_sum[18] ? 18'h3FFFF : e_sum[17:0];
  assign warm_done = (e_sat >= wt_r) || (speed_r > 17'd8800);
  assign dec_prod  = 30'(dt_r) * 30'(8000);
  assign dec_step  = dec_prod[29:16];
  assign up_prod   = 34'(dt_r) * 34'(80000);
  assign dn_prod   = 32'(dt_r) * 32'(24000);
  assign err       = $signed({1'b0, target_r}) - $signed({1'b0, speed_r});
  assign diff      = $signed({1'b0, speed_r}) - $signed({1'b0, prev_r});
  assign dt_in     = (in_data[32:16] > 17'd65536) ? 17'd65536 : in_data[32:16];
  assign mag       = (raw_r < 0) ? 32'(-raw_r) : 32'(raw_r);

  assign status.mode     = mode_r;
  assign status.ign      = ign_r;
  assign status.warm_go  = warm_r && !warm_done;
  assign status.gov_en   = armed_r && (target_r != 17'd0);
  assign status.gov_slow = speed_r < 17'd1600;
  assign status.out_full = ov_r;
  assign out_valid       = ov_r;
  assign out_data        = od_r;

  // Operand select for the shared 25x25 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_WARM0: begin mul_a = 25'(elapsed_r); mul_b = 25'(wr_r); end
      OP_SM0:   begin mul_a = 25'(w_r); mul_b = 25'(62259); end
      OP_SM2:   begin mul_a = 25'(sreq_r); mul_b = 25'(w_r); end
      OP_SM3:   begin mul_a = 25'(sl_r); mul_b = 25'(17'd65536 - {1'b0, w_r}); end
      OP_G0:    begin mul_a = 25'(err); mul_b = 25'(dt_r); end
      OP_G1:    begin mul_a = 25'(err); mul_b = $signed({1'b0, pg_r}); end
      OP_G2:    begin mul_a = 25'(diff); mul_b = 25'(1678); end
      OP_G3:    begin mul_a = 25'(integ_r); mul_b = $signed({1'b0, ig_r}); end
      OP_G5:    begin mul_a = 25'(mag[16:0]); mul_b = 25'(mag[16:0]); end
      OP_T0:    begin mul_a = 25'(load_r); mul_b = 25'(83200); end
      OP_P0:    begin mul_a = 25'(load_r); mul_b = 25'(60795); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Step arithmetic
  always_comb begin
    wsum = 33'(prod_r[31:0]) + 33'(ratio_term(sreq_r)) + 33'(32768);
    ssum = acc_r + 33'(prod_r[31:0]) + 33'(32768);
    psum = 33'(prod_r[31:0]) + 33'(65536);
    ia   = 37'(integ_r) + 37'($signed(prod_r[36:4]));
    tot  = sum_r + 56'(prod_r);
    // square-law shaping and saturation
    if (raw_r >= 32'sd32768) curved = (raw_r > 32'sd262143) ? 18'h3FFFF : raw_r[17:0];
    else if (mag[31:17] != '0) curved = 18'h3FFFF;
    else if (prod_r[33]) curved = 18'h3FFFF;
    else curved = prod_r[32:15];
    // rate limit around the last output
    hi     = {1'b0, glast_r} + {3'b0, dt_r[16:1]};
    lo_chk = {1'b0, curved} + {3'b0, dt_r[16:1]};
    if ({1'b0, curved} > hi) lim = hi[17:0];
    else if (lo_chk < {1'b0, glast_r}) lim = glast_r - {2'b0, dt_r[16:1]};
    else lim = curved;
    g = (lim > 18'd65535) ? 16'hFFFF : lim[15:0];
    // target speed and slew
    tgt0 = 18'd12800 + 18'(prod_r[32:16]);
    if (latch_r && (speed_r < 17'd9600))
      tgt1 = ((tgt0 > 18'd16000) ? 18'd16000 : tgt0) + 18'(dec_step);
    else tgt1 = tgt0;
    spd_up = 19'(speed_r) + 19'(up_prod[33:16]);
    dn_lim = 19'(tgt1) + 19'(dn_prod[31:16]);
    if (tgt1 > 18'(speed_r)) spd_new = (spd_up < 19'(tgt1)) ? spd_up : 19'(tgt1);
    else if (19'(speed_r) > dn_lim) spd_new = 19'(speed_r) - 19'(dn_prod[31:16]);
    else spd_new = 19'(tgt1);
  end

  // Next values of state and work registers
  always_comb begin
    target_nxt = target_r; pg_nxt = pg_r; ig_nxt = ig_r; wt_nxt = wt_r; wr_nxt = wr_r;
    speed_nxt = speed_r; prev_nxt = prev_r; sl_nxt = sl_r; w_nxt = w_r;
    integ_nxt = integ_r; glast_nxt = glast_r; elapsed_nxt = elapsed_r;
    warm_nxt = warm_r; latch_nxt = latch_r; armed_nxt = armed_r;
    sreq_nxt = sreq_r; load_nxt = load_r; acc_nxt = acc_r; sum_nxt = sum_r;
    raw_nxt = raw_r; press_nxt = press_r;
    case (cmd.op)
      OP_LOAD: begin
        load_nxt = '0;
        sreq_nxt = req_r;
        if (mode_r) begin
          speed_nxt = '0; sl_nxt = '0; warm_nxt = 1'b1; elapsed_nxt = '0;
        end else begin
          if (start_r) latch_nxt = 1'b1;
          if (!ign_r) begin
            speed_nxt = (speed_r > 17'(dec_step)) ? speed_r - 17'(dec_step) : '0;
            armed_nxt = 1'b0;
          end else if (warm_r) begin
            elapsed_nxt = e_sat;
            if (warm_done) warm_nxt = 1'b0;
          end
        end
      end
      OP_WARM1: sreq_nxt = (prod_r[33:16] > 18'd65535) ? 16'hFFFF : prod_r[31:16];
      OP_SM1:   w_nxt = wsum[31:16];
      OP_SM3:   acc_nxt = prod_r[32:0];
      OP_SM4: begin
        sl_nxt   = ssum[31:16];
        sreq_nxt = ssum[31:16];
        load_nxt = ssum[31:16];
      end
      OP_GSLOW: if (load_r < 16'd6554) load_nxt = 16'd6554;
      OP_G1: begin
        if (ia > 37'sd32768) integ_nxt = 18'sd32768;
        else if (ia < -37'sd32768) integ_nxt = -18'sd32768;
        else integ_nxt = ia[17:0];
      end
      OP_G2: sum_nxt = {prod_r[43:0], 12'b0};
      OP_G3: if (speed_r < 17'd32000) sum_nxt = sum_r - {prod_r[43:0], 12'b0};
      OP_G4: raw_nxt = tot[55:24];
      OP_G6: begin
        glast_nxt = lim;
        prev_nxt  = speed_r;
        if (g > load_r) load_nxt = g;
      end
      OP_T1: begin
        speed_nxt = (spd_new > 19'h1FFFF) ? 17'h1FFFF : spd_new[16:0];
        if (latch_r && (spd_new > 19'd9600)) latch_nxt = 1'b0;
      end
      OP_P1:   press_nxt = 18'd101325 + 18'(psum[32:17]);
      default: ;
    endcase
    // Register writes; the user must write only while idle, the block does not enforce it
    if (cfg_we) begin
      case (cfg_addr)
        REG_TARGET_SPEED: begin target_nxt = cfg_wdata[16:0]; armed_nxt = 1'b1; end
        REG_PROP_GAIN:    pg_nxt = cfg_wdata;
        REG_INTEG_GAIN:   ig_nxt = cfg_wdata;
        REG_WARMUP_TIME:  wt_nxt = cfg_wdata[17:0];
        REG_WARMUP_RATE:  wr_nxt = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Result valid flag
  always_comb begin
    if (cmd.op == OP_OUT) ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
    else ov_nxt = ov_r;
  end

  // Configuration, state and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST; pg_r <= PGAIN_RST; ig_r <= IGAIN_RST;
      wt_r <= WTIME_RST; wr_r <= WRATE_RST;
      speed_r <= '0; prev_r <= '0; sl_r <= '0; w_r <= WEIGHT_RST;
      integ_r <= '0; glast_r <= '0; elapsed_r <= '0;
      warm_r <= 1'b1; latch_r <= 1'b0; armed_r <= 1'b1; ov_r <= 1'b0;
    end else begin
      target_r <= target_nxt; pg_r <= pg_nxt; ig_r <= ig_nxt;
      wt_r <= wt_nxt; wr_r <= wr_nxt;
      speed_r <= speed_nxt; prev_r <= prev_nxt; sl_r <= sl_nxt; w_r <= w_nxt;
      integ_r <= integ_nxt; glast_r <= glast_nxt; elapsed_r <= elapsed_nxt;
      warm_r <= warm_nxt; latch_r <= latch_nxt; armed_r <= armed_nxt; ov_r <= ov_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    sreq_r  <= sreq_nxt;
    load_r  <= load_nxt;
    acc_r   <= acc_nxt;
    sum_r   <= sum_nxt;
    raw_r   <= raw_nxt;
    press_r <= press_nxt;
    if (cmd.accept) begin
      mode_r  <= in_mode;
      req_r   <= in_data[15:0];
      dt_r    <= dt_in;
      ign_r   <= in_data[33];
      start_r <= in_data[34];
    end
    if (cmd.op == OP_OUT)
      od_r <= {2'b0, armed_r, warm_r, latch_r, press_r, load_r, speed_r};
  end

endmodule

`default_nettype wire

>>> sv/engine_speed_governor_step.sv
`timescale 1ns / 1ps
`default_nettype none

`include "engine_speed_governor_step_defines.svh"

// Engine speed governor, one control tick per item. Configuration registers are
// written through cfg_we/cfg_addr/cfg_wdata (0 target speed, 1 proportional gain,
// 2 integral gain, 3 warm-up time, 4 warm-up rate); the user must write them only
// while no item is in flight; the block does not enforce it. A sequencer steps one
// shared 25x25 multiplier through the tick, so one item occupies the block from
// accept to the next accept, shortest on restart or ignition off and longest for
// warm-up with double smoothing and the full governor. A result waits in an output
// register; the block stops only if it is still full when the next result is ready.
module engine_speed_governor_step
  import esg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] throttle_request, [32:16] delta_time, [33] ignition_on,
  // [34] starter_press, [39:35] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [16:0] engine_speed, [32:17] engine_load, [50:33] manifold_pressure,
  // [51] starter_active, [52] warming_up, [53] governor_on, [55:54] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  esg_cmd_t    cmd;
  esg_status_t status;

  esg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_tready)
  );

  esg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // One item at a time: busy right after an accept
  `ESG_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // A result is only loaded into a free or draining output register
  `ESG_ASSERT_IMP(a_out_free, cmd.op == OP_OUT, !out_tvalid || out_tready)
  // Loading the result raises valid
  `ESG_ASSERT_NXT(a_out_loaded, cmd.op == OP_OUT, out_tvalid)

endmodule

`default_nettype wire
